// ===== rtl/jts_pkg.sv =====
// Shared types, byte codes and helper functions for the JSON token splitter.
// Depends on nothing; imported by json_token_splitter.
package jts_pkg;

	localparam int POS_W = 24;
	localparam int OUT_POS_W = 24;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
	localparam int MAX_TOKENS = 3;

	localparam logic [2:0] KIND_OP = 3'd0;
	localparam logic [2:0] KIND_QUOTE = 3'd1;
	localparam logic [2:0] KIND_BODY = 3'd2;
	localparam logic [2:0] KIND_WORD = 3'd3;
	localparam logic [2:0] KIND_END = 3'd4;
	localparam logic [2:0] KIND_ERR = 3'd5;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_COMMENT = 2'd1;
	localparam logic [1:0] ERR_STRING = 2'd2;
	localparam logic [1:0] ERR_ESCAPE = 2'd3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;

	typedef struct packed {
		logic [2:0]           kind;
		logic [OUT_POS_W-1:0] start;
		logic [OUT_POS_W-1:0] length;
		logic [7:0]           op_char;
		logic [1:0]           err;
		logic                 last;
	} token_t;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
		return (p == POS_MAX) ? p : p + {{(POS_W-1){1'b0}}, 1'b1};
	endfunction

	// Distance from the token start to the current position, zero if negative.
	function automatic logic [POS_W-1:0] span(input logic [POS_W-1:0] p,
			input logic [POS_W-1:0] s);
		return (p >= s) ? p - s : '0;
	endfunction

	function automatic token_t make_tok(input logic [2:0] kind,
			input logic [POS_W-1:0] start, input logic [POS_W-1:0] length,
			input logic [7:0] op_char, input logic [1:0] err);
		token_t t;
		t.kind = kind;
		t.start = OUT_POS_W'(start);
		t.length = OUT_POS_W'(length);
		t.op_char = op_char;
		t.err = err;
		t.last = 1'b0;
		return t;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	function automatic logic is_operator(input logic [7:0] b);
		return b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK ||
			b == CH_RBRACK || b == CH_COLON || b == CH_COMMA;
	endfunction

endpackage

// ===== rtl/json_token_splitter.sv =====
// Top level of the JSON token splitter: input byte register, lexer state
// machine and a token queue toward the output stream.
// Depends on jts_pkg.

// Takes one document byte per transfer on the slave stream (tlast marks the
// document's last byte) and sends tokens on the master stream, one token per
// transfer. An accepted byte is registered, then the lexer turns it into zero
// to three tokens at once and writes them into a 16-entry token queue.
// A byte is accepted in every cycle while the queue has room for the tokens
// of the byte in flight and of the new one, so bytes stream at one per cycle
// and output is limited to one token per cycle. The input byte register and
// the token queue lie between a byte and its tokens. After the end-of-document
// byte all lexer state returns to reset, so the next byte opens a new document.
module json_token_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] byte_value
	input  logic        s_tlast,   // end_of_document
	output logic        m_tvalid,
	input  logic        m_tready,
	// [23:0] token_start, [47:24] token_length, [55:48] operator_char,
	// [57:56] error_code, [63:58] zero
	output logic [63:0] m_tdata,
	output logic [2:0]  m_tuser,   // [2:0] token_kind
	output logic        m_tlast    // last_of_run
);
	import jts_pkg::*;

	typedef enum logic [2:0] {
		M_NORMAL,
		M_SLASH,
		M_LINE,
		M_BLOCK,
		M_BLOCK_STAR,
		M_STRING,
		M_ESCAPE,
		M_WORD
	} mode_t;

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eod_s1;

	mode_t                 mode_q, mode_n;
	logic [POS_W-1:0]      pos_q;
	logic [POS_W-1:0]      open_q, open_n;

	token_t                tok [MAX_TOKENS];
	logic [1:0]            n_tok;
	logic                  do_norm;
	logic [POS_W-1:0]      end_pos;

	token_t                fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic [1:0]            n_push;
	logic                  pop;
	logic [FIFO_CNT_W-1:0] committed;

	// Room must remain for the tokens of the byte in the input register and
	// for those of the byte being accepted now.
	assign committed = count_q + (valid_s1 ? FIFO_CNT_W'(MAX_TOKENS) : '0);
	assign s_tready = committed <= FIFO_CNT_W'(FIFO_DEPTH - MAX_TOKENS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eod_s1 <= s_tlast;
		end
	end

	assign end_pos = sat_inc(pos_q);

	always_comb begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			tok[i] = '0;
		end
		n_tok = '0;
		mode_n = mode_q;
		open_n = open_q;
		do_norm = 1'b0;

		unique case (mode_q)
			M_SLASH: begin
				if (byte_s1 == CH_SLASH) begin
					mode_n = M_LINE;
				end else if (byte_s1 == CH_STAR) begin
					mode_n = M_BLOCK;
				end else begin
					do_norm = 1'b1;
				end
			end
			M_LINE: begin
				if (byte_s1 == CH_LF) begin
					mode_n = M_NORMAL;
				end
			end
			M_BLOCK: begin
				if (byte_s1 == CH_STAR) begin
					mode_n = M_BLOCK_STAR;
				end
			end
			M_BLOCK_STAR: begin
				if (byte_s1 == CH_SLASH) begin
					mode_n = M_NORMAL;
				end else if (byte_s1 != CH_STAR) begin
					mode_n = M_BLOCK;
				end
			end
			M_STRING: begin
				if (byte_s1 == CH_QUOTE) begin
					tok[n_tok] = make_tok(KIND_BODY, open_q, span(pos_q, open_q), 8'h00,
						ERR_NONE);
					n_tok = n_tok + 2'd1;
					tok[n_tok] = make_tok(KIND_QUOTE, pos_q, POS_W'(1), byte_s1, ERR_NONE);
					n_tok = n_tok + 2'd1;
					mode_n = M_NORMAL;
				end else if (byte_s1 == CH_BSLASH) begin
					mode_n = M_ESCAPE;
				end
			end
			M_ESCAPE: begin
				mode_n = M_STRING;
			end
			M_WORD: begin
				if (is_blank(byte_s1) || is_operator(byte_s1) || byte_s1 == CH_QUOTE) begin
					tok[n_tok] = make_tok(KIND_WORD, open_q, span(pos_q, open_q), 8'h00,
						ERR_NONE);
					n_tok = n_tok + 2'd1;
					do_norm = 1'b1;
				end
			end
			M_NORMAL: begin
				do_norm = 1'b1;
			end
		endcase

		// Handling of a byte that arrives between tokens.
		if (do_norm) begin
			mode_n = M_NORMAL;
			if (is_blank(byte_s1)) begin
				mode_n = M_NORMAL;
			end else if (byte_s1 == CH_SLASH) begin
				open_n = pos_q;
				mode_n = M_SLASH;
			end else if (is_operator(byte_s1)) begin
				tok[n_tok] = make_tok(KIND_OP, pos_q, POS_W'(1), byte_s1, ERR_NONE);
				n_tok = n_tok + 2'd1;
			end else if (byte_s1 == CH_QUOTE) begin
				tok[n_tok] = make_tok(KIND_QUOTE, pos_q, POS_W'(1), byte_s1, ERR_NONE);
				n_tok = n_tok + 2'd1;
				open_n = sat_inc(pos_q);
				mode_n = M_STRING;
			end else begin
				open_n = pos_q;
				mode_n = M_WORD;
			end
		end

		if (eod_s1) begin
			unique case (mode_n)
				M_SLASH, M_BLOCK, M_BLOCK_STAR: begin
					tok[n_tok] = make_tok(KIND_ERR, open_n, '0, 8'h00, ERR_COMMENT);
					n_tok = n_tok + 2'd1;
				end
				M_STRING: begin
					tok[n_tok] = make_tok(KIND_ERR, open_n, '0, 8'h00, ERR_STRING);
					n_tok = n_tok + 2'd1;
				end
				M_ESCAPE: begin
					tok[n_tok] = make_tok(KIND_ERR, open_n, '0, 8'h00, ERR_ESCAPE);
					n_tok = n_tok + 2'd1;
				end
				M_WORD: begin
					tok[n_tok] = make_tok(KIND_WORD, open_n, span(end_pos, open_n), 8'h00,
						ERR_NONE);
					n_tok = n_tok + 2'd1;
					tok[n_tok] = make_tok(KIND_END, end_pos, '0, 8'h00, ERR_NONE);
					n_tok = n_tok + 2'd1;
				end
				M_NORMAL, M_LINE: begin
					tok[n_tok] = make_tok(KIND_END, end_pos, '0, 8'h00, ERR_NONE);
					n_tok = n_tok + 2'd1;
				end
			endcase
		end

		for (int i = 0; i < MAX_TOKENS; i++) begin
			tok[i].last = (n_tok != 2'd0) && (2'(i) == n_tok - 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_NORMAL;
			pos_q <= '0;
			open_q <= '0;
		end else if (valid_s1) begin
			if (eod_s1) begin
				mode_q <= M_NORMAL;
				pos_q <= '0;
				open_q <= '0;
			end else begin
				mode_q <= mode_n;
				pos_q <= end_pos;
				open_q <= open_n;
			end
		end
	end

	// Token queue.
	assign n_push = valid_s1 ? n_tok : 2'd0;
	assign pop = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (2'(i) < n_push) begin
				fifo_q[wr_ptr_q + FIFO_PTR_W'(i)] <= tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			count_q <= count_q + FIFO_CNT_W'(n_push) - (pop ? FIFO_CNT_W'(1) : '0);
		end
	end

	assign m_tvalid = count_q != '0;
	assign m_tuser = fifo_q[rd_ptr_q].kind;
	assign m_tlast = fifo_q[rd_ptr_q].last;
	assign m_tdata = {6'b0, fifo_q[rd_ptr_q].err, fifo_q[rd_ptr_q].op_char,
		fifo_q[rd_ptr_q].length, fifo_q[rd_ptr_q].start};

endmodule
